/* design/drbc_pkg.sv */
package drbc_pkg;

  localparam int unsigned CoordBits   = 16;
  localparam int unsigned HistFrames  = 2;
  localparam int unsigned OutBits     = 16;
  localparam int unsigned CfgBits     = 14;
  localparam int unsigned CfgIdxBits  = 3;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
  } box_t;

  typedef enum logic [1:0] {
    FuncAddPoint    = 2'd0,
    FuncWholeScreen = 2'd1,
    FuncEndFrame    = 2'd2
  } func_e;

  typedef enum logic [CfgIdxBits-1:0] {
    RegScreenWidth  = 3'd0,
    RegScreenHeight = 3'd1,
    RegViewLeft     = 3'd2,
    RegViewTop      = 3'd3,
    RegViewWidth    = 3'd4,
    RegViewHeight   = 3'd5,
    RegFullScreen   = 3'd6
  } cfg_reg_e;

endpackage

/* design/dirty_rect_border_clear.sv */
// Dirty-rectangle tracker. Each add-point or whole-screen item is folded into the current
// frame's bounding box in the cycle it is accepted, so those items flow at one per clock.
// An end-frame item (only when full_screen is clear) merges the current box with the two
// previous frames' boxes, shifts the history and restarts the box; in the next cycle the
// border conditions are evaluated and then one border rectangle (above, below, left,
// right of the viewport, in that order) is produced per cycle while the output is not
// stalled, up to four, with last_rect marking the final one. While the conditions are
// evaluated and rectangles produced, a further end-frame item is held off by in_stall_o;
// other items are still taken, also while the consumer stalls the output register.
// Configuration writes are always taken (cfg_ready_o is tied high) and should be made only when idle.
module dirty_rect_border_clear (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [drbc_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [drbc_pkg::CfgBits-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             func_i,
  input  logic signed [15:0]                     point_x_i,
  input  logic signed [15:0]                     point_y_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [drbc_pkg::OutBits-1:0]    rect_x_o,
  output logic signed [drbc_pkg::OutBits-1:0]    rect_y_o,
  output logic signed [drbc_pkg::OutBits-1:0]    rect_w_o,
  output logic signed [drbc_pkg::OutBits-1:0]    rect_h_o,
  output logic                                   last_rect_o
);

  localparam int unsigned BitTop    = 0;
  localparam int unsigned BitBottom = 1;
  localparam int unsigned BitLeft   = 2;
  localparam int unsigned BitRight  = 3;

  localparam drbc_pkg::coord_t One       = drbc_pkg::coord_t'(1);
  localparam drbc_pkg::coord_t Zero      = drbc_pkg::coord_t'(0);
  localparam drbc_pkg::coord_t EmptyLow  = drbc_pkg::coord_t'(9999);
  localparam drbc_pkg::coord_t EmptyHigh = drbc_pkg::coord_t'(-9999);
  localparam drbc_pkg::box_t   EmptyBox  = '{EmptyLow, EmptyLow, EmptyHigh, EmptyHigh};

  logic [drbc_pkg::CfgBits-1:0] screen_width_q, screen_height_q;
  logic [drbc_pkg::CfgBits-1:0] view_left_q, view_top_q, view_width_q, view_height_q;
  logic                         full_screen_q;

  drbc_pkg::box_t cur_q, cur_d;
  drbc_pkg::box_t hist_q [drbc_pkg::HistFrames];
  drbc_pkg::box_t hist_d [drbc_pkg::HistFrames];
  drbc_pkg::box_t cun_q, cun_d, uni;
  drbc_pkg::box_t step_box;
  logic           pend_q, pend_d;
  logic [3:0]     mask_q, mask_d;
  logic [3:0]     sel;
  logic           busy, in_fire, step, end_fire;

  drbc_pkg::coord_t px, py, sx, sy;
  drbc_pkg::coord_t top, bottom, left, right, lim;
  drbc_pkg::coord_t rx, ry, rw, rh;

  logic                                out_valid_q;
  logic signed [drbc_pkg::OutBits-1:0] rect_x_q, rect_y_q, rect_w_q, rect_h_q;
  logic                                last_q;

  function automatic drbc_pkg::box_t widen(drbc_pkg::box_t b, drbc_pkg::coord_t x,
                                           drbc_pkg::coord_t y);
    drbc_pkg::box_t r;
    r = b;
    if (x < r.x1) r.x1 = x;
    if (x > r.x2) r.x2 = x;
    if (y < r.y1) r.y1 = y;
    if (y > r.y2) r.y2 = y;
    return r;
  endfunction

  function automatic drbc_pkg::box_t merge(drbc_pkg::box_t a, drbc_pkg::box_t b);
    drbc_pkg::box_t r;
    r = a;
    if (b.x1 < r.x1) r.x1 = b.x1;
    if (b.x2 > r.x2) r.x2 = b.x2;
    if (b.y1 < r.y1) r.y1 = b.y1;
    if (b.y2 > r.y2) r.y2 = b.y2;
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;

  assign busy       = pend_q | (|mask_q);
  assign in_stall_o = busy & in_valid_i & (func_i == drbc_pkg::FuncEndFrame);
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign end_fire   = in_fire & (func_i == drbc_pkg::FuncEndFrame) & ~full_screen_q;

  assign px = drbc_pkg::coord_t'(point_x_i);
  assign py = drbc_pkg::coord_t'(point_y_i);
  assign sx = drbc_pkg::coord_t'(screen_width_q) - One;
  assign sy = drbc_pkg::coord_t'(screen_height_q) - One;

  assign top    = drbc_pkg::coord_t'(view_top_q);
  assign bottom = top + drbc_pkg::coord_t'(view_height_q) - One;
  assign left   = drbc_pkg::coord_t'(view_left_q);
  assign right  = left + drbc_pkg::coord_t'(view_width_q) - One;

  // union of the current box and the history
  always_comb begin
    uni = cur_q;
    for (int i = 0; i < drbc_pkg::HistFrames; i++) begin
      uni = merge(uni, hist_q[i]);
    end
  end

  // box update and history shift
  always_comb begin
    cur_d  = cur_q;
    hist_d = hist_q;
    cun_d  = cun_q;
    if (in_fire) begin
      case (func_i)
        drbc_pkg::FuncAddPoint: begin
          cur_d = widen(cur_q, px, py);
        end
        drbc_pkg::FuncWholeScreen: begin
          cur_d = widen(widen(cur_q, Zero, Zero), sx, sy);
        end
        drbc_pkg::FuncEndFrame: begin
          if (!full_screen_q) begin
            for (int i = drbc_pkg::HistFrames - 1; i > 0; i--) begin
              hist_d[i] = hist_q[i-1];
            end
            hist_d[0] = cur_q;
            cur_d     = EmptyBox;
            cun_d     = uni;
          end
        end
        default: ;
      endcase
    end
  end

  // border rectangle for the lowest pending side
  always_comb begin
    sel      = mask_q & (~mask_q + 4'd1);
    step_box = cun_q;
    lim      = Zero;
    rx       = cun_q.x1;
    ry       = cun_q.y1;
    rw       = cun_q.x2 - cun_q.x1 + One;
    rh       = cun_q.y2 - cun_q.y1 + One;
    if (mask_q[BitTop]) begin
      lim = top - One;
      if (cun_q.y2 < lim) lim = cun_q.y2;
      rh          = lim - cun_q.y1 + One;
      step_box.y1 = top;
    end else if (mask_q[BitBottom]) begin
      lim = bottom + One;
      if (cun_q.y1 > lim) lim = cun_q.y1;
      ry          = lim;
      rh          = cun_q.y2 - lim + One;
      step_box.y2 = bottom;
    end else if (mask_q[BitLeft]) begin
      lim = left - One;
      if (cun_q.x2 < lim) lim = cun_q.x2;
      rw          = lim - cun_q.x1 + One;
      step_box.x1 = left;
    end else begin
      lim = right + One;
      if (cun_q.x1 > lim) lim = cun_q.x1;
      rx          = lim;
      rw          = cun_q.x2 - lim + One;
      step_box.x2 = right;
    end
  end

  assign step = (|mask_q) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    pend_d = pend_q;
    mask_d = mask_q;
    if (pend_q) begin
      pend_d = 1'b0;
      mask_d = '0;
      if (cun_q.y2 > cun_q.y1) begin
        mask_d[BitTop]    = cun_q.y1 < top;
        mask_d[BitBottom] = cun_q.y2 > bottom;
        mask_d[BitLeft]   = cun_q.x1 < left;
        mask_d[BitRight]  = cun_q.x2 > right;
      end
    end else if (step) begin
      mask_d = mask_q & ~sel;
    end
    if (end_fire) begin
      pend_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= drbc_pkg::CfgBits'(640);
      screen_height_q <= drbc_pkg::CfgBits'(480);
      view_left_q     <= '0;
      view_top_q      <= '0;
      view_width_q    <= drbc_pkg::CfgBits'(640);
      view_height_q   <= drbc_pkg::CfgBits'(480);
      full_screen_q   <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        drbc_pkg::RegScreenWidth:  screen_width_q  <= cfg_data_i;
        drbc_pkg::RegScreenHeight: screen_height_q <= cfg_data_i;
        drbc_pkg::RegViewLeft:     view_left_q     <= cfg_data_i;
        drbc_pkg::RegViewTop:      view_top_q      <= cfg_data_i;
        drbc_pkg::RegViewWidth:    view_width_q    <= cfg_data_i;
        drbc_pkg::RegViewHeight:   view_height_q   <= cfg_data_i;
        drbc_pkg::RegFullScreen:   full_screen_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      for (int i = 0; i < drbc_pkg::HistFrames; i++) begin
        hist_q[i] <= '0;
      end
      pend_q      <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_q  <= cur_d;
      hist_q <= hist_d;
      pend_q <= pend_d;
      mask_q <= mask_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      cun_q <= cun_q;
    end else if (step) begin
      cun_q <= step_box;
    end else begin
      cun_q <= cun_d;
    end
    if (step) begin
      rect_x_q <= drbc_pkg::OutBits'(rx);
      rect_y_q <= drbc_pkg::OutBits'(ry);
      rect_w_q <= drbc_pkg::OutBits'(rw);
      rect_h_q <= drbc_pkg::OutBits'(rh);
      last_q   <= (mask_q & ~sel) == 4'd0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rect_x_o    = rect_x_q;
  assign rect_y_o    = rect_y_q;
  assign rect_w_o    = rect_w_q;
  assign rect_h_o    = rect_h_q;
  assign last_rect_o = last_q;

endmodule

/* design/drbc_checker.sv */
module drbc_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                cfg_valid_i,
  input logic                                cfg_ready_o,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [1:0]                          func_i,
  input logic signed [15:0]                  point_x_i,
  input logic signed [15:0]                  point_y_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [drbc_pkg::OutBits-1:0] rect_x_o,
  input logic signed [drbc_pkg::OutBits-1:0] rect_y_o,
  input logic signed [drbc_pkg::OutBits-1:0] rect_w_o,
  input logic signed [drbc_pkg::OutBits-1:0] rect_h_o,
  input logic                                last_rect_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(rect_x_o) && $stable(rect_y_o)
      && $stable(rect_w_o) && $stable(rect_h_o) && $stable(last_rect_o))
    else $error("stalled result changed");

  // only end-frame items are ever held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_i && (func_i == drbc_pkg::FuncEndFrame))
    else $error("stall on an item that is always taken");

  // a stalled input transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(func_i) && $stable(point_x_i)
      && $stable(point_y_i))
    else $error("stalled input changed");

  // config writes never wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind dirty_rect_border_clear drbc_checker u_drbc_checker (.*);
